/* hw/rtl/ntsp_pkg.sv */
// Shared types, character codes and helpers for the NMEA time sentence parser.
// No dependencies; used by every module of the block.
package ntsp_pkg;

  // line buffer depth: characters at index LINE_MAX-1 and beyond are dropped
  localparam int unsigned LINE_MAX = 256;
  localparam int unsigned LEN_W    = $clog2(LINE_MAX);
  localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_MAX - 1);

  localparam logic [31:0] FRESH_RESET    = 32'd300000;
  localparam logic [31:0] SUPPRESS_RESET = 32'd4000;

  // register indexes
  localparam logic [1:0] REG_FRESH    = 2'd0;
  localparam logic [1:0] REG_SUPPRESS = 2'd1;

  // item kinds
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // character codes
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_Q      = 8'h51;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_Z      = 8'h5A;

  // zone field limits
  localparam logic [9:0] HOUR_LIMIT = 10'd13;
  localparam logic [9:0] MIN_LIMIT  = 10'd59;

  localparam int unsigned DAY_MIN = 1440;

  // scan phase of the current line
  typedef enum logic [2:0] {
    PH_LEAD,      // leading blanks before '$'
    PH_HDR,       // header up to the first comma
    PH_F1_BLANK,  // blanks before the time digits
    PH_F1_DIG,    // collecting hhmmss
    PH_F1_REST,   // rest of the time field
    PH_ZONE,      // past the second comma
    PH_FAIL       // line rejected
  } ntsp_phase_t;

  // signed number reader state
  typedef enum logic [1:0] {
    RD_BLANK,
    RD_DIGITS,
    RD_DONE
  } ntsp_rd_sub_t;

  typedef struct packed {
    ntsp_rd_sub_t sub;
    logic         neg;
    logic [9:0]   val;
  } ntsp_rd_t;

  // state handed from the line scanner to the output stages
  typedef struct packed {
    logic        valid;
    logic        taken;
    logic        have_time;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [10:0] utc_total;
    logic [31:0] time_stamp;
    logic [31:0] now_count;
    logic [14:0] zone_offset;
  } ntsp_status_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
           (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // one character of a signed zone field
  function automatic ntsp_rd_t rd_step(input ntsp_rd_t cur, input logic [7:0] c,
                                       input logic [9:0] limit);
    ntsp_rd_t    nxt;
    logic [13:0] acc;
    nxt = cur;
    acc = 14'(cur.val) * 14'd10 + 14'(c[3:0]);
    unique case (cur.sub)
      RD_BLANK: begin
        if (is_blank(c)) begin
          nxt.sub = RD_BLANK;
        end else if (c == CH_MINUS) begin
          nxt.neg = 1'b1;
          nxt.sub = RD_DIGITS;
        end else if (c == CH_PLUS) begin
          nxt.sub = RD_DIGITS;
        end else if (is_digit(c)) begin
          nxt.val = 10'(c[3:0]);
          nxt.sub = (10'(c[3:0]) > limit) ? RD_DONE : RD_DIGITS;
        end else begin
          nxt.sub = RD_DONE;
        end
      end
      RD_DIGITS: begin
        if (is_digit(c)) begin
          nxt.val = acc[9:0];
          nxt.sub = (acc[9:0] > limit) ? RD_DONE : RD_DIGITS;
        end else begin
          nxt.sub = RD_DONE;
        end
      end
      default: nxt.sub = RD_DONE;
    endcase
    return nxt;
  endfunction

endpackage

/* hw/rtl/ntsp_line_scan.sv */
// Byte-by-byte sentence scanner: header, time field and zone fields, commit at line end.
// Also holds the millisecond counter and latched time. Depends on ntsp_pkg.
module ntsp_line_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                item_valid,
  input  logic                item_func,
  input  logic [7:0]          item_byte,
  input  logic [31:0]         suppress_ms,
  output ntsp_pkg::ntsp_status_t status
);

  logic [31:0]                now_r, now_nxt;
  logic [ntsp_pkg::LEN_W-1:0] len_r, len_nxt;
  ntsp_pkg::ntsp_phase_t      phase_r, phase_nxt;
  logic [2:0]                 hlen_r, hlen_nxt;
  logic                       zok_r, zok_nxt;
  logic                       rg_r, rg_nxt;
  logic                       zda_r, zda_nxt;
  logic [7:0]                 prev1_r, prev1_nxt;
  logic [7:0]                 prev2_r, prev2_nxt;
  logic [2:0]                 dcnt_r, dcnt_nxt;
  logic [23:0]                digits_r, digits_nxt;
  logic [2:0]                 commas_r, commas_nxt;
  ntsp_pkg::ntsp_rd_t         hrd_r, hrd_nxt;
  ntsp_pkg::ntsp_rd_t         mrd_r, mrd_nxt;
  logic [4:0]                 hour_r, hour_nxt;
  logic [5:0]                 minute_r, minute_nxt;
  logic [10:0]                total_r, total_nxt;
  logic                       have_r, have_nxt;
  logic [31:0]                stamp_r, stamp_nxt;
  logic [31:0]                zda_stamp_r, zda_stamp_nxt;
  logic [14:0]                offset_r, offset_nxt;
  logic                       valid_r;
  logic                       taken_r, taken_nxt;

  logic [7:0]  c;
  logic [2:0]  hpos;
  logic        rg_hit;
  logic [6:0]  hh, mm, ss;
  logic        time_ok;
  logic        suppressed;
  logic [31:0] zda_age;
  logic [15:0] hrs_s, mins_s, off_s;
  ntsp_pkg::ntsp_rd_t rd_init;

  assign c = item_byte;
  assign rd_init = '{sub: ntsp_pkg::RD_BLANK, neg: 1'b0, val: 10'd0};

  // header position of the current character, counted after '$'
  assign hpos = (hlen_r == 3'd7) ? 3'd7 : hlen_r + 3'd1;
  assign rg_hit = ((prev2_r == ntsp_pkg::CH_R) && (prev1_r == ntsp_pkg::CH_M) &&
                   (c == ntsp_pkg::CH_C)) ||
                  ((prev2_r == ntsp_pkg::CH_G) && (prev1_r == ntsp_pkg::CH_G) &&
                   (c == ntsp_pkg::CH_A));

  // time digits and suppression check for the line end
  assign hh = 7'(digits_r[23:20]) * 7'd10 + 7'(digits_r[19:16]);
  assign mm = 7'(digits_r[15:12]) * 7'd10 + 7'(digits_r[11:8]);
  assign ss = 7'(digits_r[7:4])   * 7'd10 + 7'(digits_r[3:0]);
  assign time_ok = (hh <= 7'd23) && (mm <= 7'd59) && (ss <= 7'd59);
  assign zda_age = now_r - zda_stamp_r;
  assign suppressed = rg_r && (zda_stamp_r != 32'd0) && (zda_age < suppress_ms);

  // zone offset from the two fields
  assign hrs_s  = hrd_r.neg ? -16'(hrd_r.val) : 16'(hrd_r.val);
  assign mins_s = (mrd_r.val > ntsp_pkg::MIN_LIMIT) ? 16'd0 :
                  (mrd_r.neg ? -16'(mrd_r.val) : 16'(mrd_r.val));
  assign off_s  = hrs_s * 16'd60 + mins_s;

  // next state for one request
  always_comb begin
    now_nxt       = now_r;
    len_nxt       = len_r;
    phase_nxt     = phase_r;
    hlen_nxt      = hlen_r;
    zok_nxt       = zok_r;
    rg_nxt        = rg_r;
    zda_nxt       = zda_r;
    prev1_nxt     = prev1_r;
    prev2_nxt     = prev2_r;
    dcnt_nxt      = dcnt_r;
    digits_nxt    = digits_r;
    commas_nxt    = commas_r;
    hrd_nxt       = hrd_r;
    mrd_nxt       = mrd_r;
    hour_nxt      = hour_r;
    minute_nxt    = minute_r;
    total_nxt     = total_r;
    have_nxt      = have_r;
    stamp_nxt     = stamp_r;
    zda_stamp_nxt = zda_stamp_r;
    offset_nxt    = offset_r;
    taken_nxt     = 1'b0;

    if (item_func == ntsp_pkg::FUNC_TICK) begin
      now_nxt = now_r + 32'd1;
    end else if ((c == ntsp_pkg::CH_CR) || (c == ntsp_pkg::CH_LF)) begin
      // line end: commit and restart
      if ((phase_r == ntsp_pkg::PH_ZONE) && time_ok && !suppressed) begin
        taken_nxt  = 1'b1;
        hour_nxt   = hh[4:0];
        minute_nxt = mm[5:0];
        total_nxt  = 11'(hh[4:0]) * 11'd60 + 11'(mm[5:0]);
        have_nxt   = 1'b1;
        stamp_nxt  = now_r;
        if (zda_r) begin
          zda_stamp_nxt = now_r;
          if (commas_r == 3'd6) offset_nxt = off_s[14:0];
        end
      end
      len_nxt   = '0;
      phase_nxt = ntsp_pkg::PH_LEAD;
    end else if (len_r != ntsp_pkg::LEN_LAST) begin
      len_nxt = len_r + 1'b1;
      unique case (phase_r)
        ntsp_pkg::PH_LEAD: begin
          if (c == ntsp_pkg::CH_DOLLAR) begin
            phase_nxt = ntsp_pkg::PH_HDR;
            hlen_nxt  = 3'd0;
            zok_nxt   = 1'b1;
            rg_nxt    = 1'b0;
            prev1_nxt = ntsp_pkg::CH_DOLLAR;
            prev2_nxt = 8'd0;
          end else if (!ntsp_pkg::is_blank(c)) begin
            phase_nxt = ntsp_pkg::PH_FAIL;
          end
        end
        ntsp_pkg::PH_HDR: begin
          if (c == ntsp_pkg::CH_COMMA) begin
            zda_nxt = (hlen_r == 3'd5) && zok_r;
            if ((hlen_r == 3'd5 && zok_r) || rg_r) begin
              phase_nxt = ntsp_pkg::PH_F1_BLANK;
            end else begin
              phase_nxt = ntsp_pkg::PH_FAIL;
            end
          end else begin
            hlen_nxt  = hpos;
            prev2_nxt = prev1_r;
            prev1_nxt = c;
            rg_nxt    = rg_r | rg_hit;
            unique case (hpos)
              3'd1:    zok_nxt = zok_r & (c == ntsp_pkg::CH_G);
              3'd2:    zok_nxt = zok_r & ((c == ntsp_pkg::CH_P) || (c == ntsp_pkg::CH_N) ||
                                          (c == ntsp_pkg::CH_L) || (c == ntsp_pkg::CH_Q));
              3'd3:    zok_nxt = zok_r & (c == ntsp_pkg::CH_Z);
              3'd4:    zok_nxt = zok_r & (c == ntsp_pkg::CH_D);
              3'd5:    zok_nxt = zok_r & (c == ntsp_pkg::CH_A);
              default: zok_nxt = 1'b0;
            endcase
          end
        end
        ntsp_pkg::PH_F1_BLANK: begin
          if (ntsp_pkg::is_digit(c)) begin
            digits_nxt = {digits_r[19:0], c[3:0]};
            dcnt_nxt   = 3'd1;
            phase_nxt  = ntsp_pkg::PH_F1_DIG;
          end else if (!ntsp_pkg::is_blank(c)) begin
            phase_nxt = ntsp_pkg::PH_FAIL;
          end
        end
        ntsp_pkg::PH_F1_DIG: begin
          if (ntsp_pkg::is_digit(c)) begin
            digits_nxt = {digits_r[19:0], c[3:0]};
            dcnt_nxt   = dcnt_r + 3'd1;
            if (dcnt_r == 3'd5) phase_nxt = ntsp_pkg::PH_F1_REST;
          end else begin
            phase_nxt = ntsp_pkg::PH_FAIL;
          end
        end
        ntsp_pkg::PH_F1_REST: begin
          if (c == ntsp_pkg::CH_COMMA) begin
            phase_nxt  = ntsp_pkg::PH_ZONE;
            commas_nxt = 3'd2;
            hrd_nxt    = rd_init;
            mrd_nxt    = rd_init;
          end
        end
        ntsp_pkg::PH_ZONE: begin
          // fifth field is the zone hour, sixth the zone minute
          if ((c == ntsp_pkg::CH_COMMA) && (commas_r < 3'd6)) begin
            commas_nxt = commas_r + 3'd1;
            if (commas_r == 3'd4) hrd_nxt = rd_init;
            if (commas_r == 3'd5) mrd_nxt = rd_init;
          end else if (commas_r == 3'd5) begin
            hrd_nxt = ntsp_pkg::rd_step(hrd_r, c, ntsp_pkg::HOUR_LIMIT);
          end else if (commas_r == 3'd6) begin
            mrd_nxt = ntsp_pkg::rd_step(mrd_r, c, ntsp_pkg::MIN_LIMIT);
          end
        end
        ntsp_pkg::PH_FAIL: phase_nxt = ntsp_pkg::PH_FAIL;
        default:           phase_nxt = ntsp_pkg::PH_FAIL;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= '0;
      len_r       <= '0;
      phase_r     <= ntsp_pkg::PH_LEAD;
      have_r      <= 1'b0;
      stamp_r     <= '0;
      zda_stamp_r <= '0;
      offset_r    <= '0;
      hour_r      <= '0;
      minute_r    <= '0;
      total_r     <= '0;
      valid_r     <= 1'b0;
      taken_r     <= 1'b0;
    end else if (en) begin
      valid_r <= item_valid;
      taken_r <= item_valid & taken_nxt;
      if (item_valid) begin
        now_r       <= now_nxt;
        len_r       <= len_nxt;
        phase_r     <= phase_nxt;
        have_r      <= have_nxt;
        stamp_r     <= stamp_nxt;
        zda_stamp_r <= zda_stamp_nxt;
        offset_r    <= offset_nxt;
        hour_r      <= hour_nxt;
        minute_r    <= minute_nxt;
        total_r     <= total_nxt;
      end
    end
  end

  // per-line scratch
  always_ff @(posedge clk) begin
    if (en && item_valid) begin
      hlen_r   <= hlen_nxt;
      zok_r    <= zok_nxt;
      rg_r     <= rg_nxt;
      zda_r    <= zda_nxt;
      prev1_r  <= prev1_nxt;
      prev2_r  <= prev2_nxt;
      dcnt_r   <= dcnt_nxt;
      digits_r <= digits_nxt;
      commas_r <= commas_nxt;
      hrd_r    <= hrd_nxt;
      mrd_r    <= mrd_nxt;
    end
  end

  assign status = '{valid: valid_r, taken: taken_r, have_time: have_r, hour: hour_r,
                    minute: minute_r, utc_total: total_r, time_stamp: stamp_r,
                    now_count: now_r, zone_offset: offset_r};

endmodule

/* hw/rtl/ntsp_local_time.sv */
// Result stages: freshness, day wrap of UTC plus offset, hour/minute split.
// Two registered stages fed by the scanner status. Depends on ntsp_pkg.
module ntsp_local_time (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  ntsp_pkg::ntsp_status_t status,
  input  logic [31:0]            fresh_ms,
  output logic                   res_valid,
  output logic [38:0]            res_data
);

  logic        v3_r;
  logic        fresh_r;
  logic        taken3_r;
  logic [4:0]  uh_r;
  logic [5:0]  um_r;
  logic [14:0] off3_r;
  logic [10:0] day_r;

  logic        out_v_r;
  logic [38:0] out_r;

  logic [31:0] age;
  logic        fresh;
  logic [15:0] shifted;
  logic [14:0] x;
  logic [20:0] q_prod;
  logic [3:0]  q;
  logic [14:0] rem;
  logic [20:0] h_prod;
  logic [4:0]  lh;
  logic [10:0] lm_full;

  // freshness window
  assign age   = status.now_count - status.time_stamp;
  assign fresh = status.have_time && (age < fresh_ms);

  // bring UTC plus offset into a positive range, then reduce mod one day:
  // x/1440 = (x>>5)/45 via a reciprocal multiply
  assign shifted = 16'(status.utc_total) + {status.zone_offset[14], status.zone_offset} +
                   16'(6 * ntsp_pkg::DAY_MIN);
  assign x       = shifted[14:0];
  assign q_prod  = 21'(x[14:5]) * 21'd1457;
  assign q       = q_prod[19:16];
  assign rem     = x - 15'(q) * 15'(ntsp_pkg::DAY_MIN);

  // hour = (r>>2)/15 via a reciprocal multiply
  assign h_prod  = 21'(day_r[10:2]) * 21'd4370;
  assign lh      = h_prod[20:16];
  assign lm_full = day_r - 11'(lh) * 11'd60;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      v3_r    <= status.valid;
      out_v_r <= v3_r;
    end
  end

  // day wrap stage
  always_ff @(posedge clk) begin
    if (en) begin
      fresh_r  <= fresh;
      taken3_r <= status.taken;
      uh_r     <= status.hour;
      um_r     <= status.minute;
      off3_r   <= status.zone_offset;
      day_r    <= rem[10:0];
    end
  end

  // result register: fresh, utc hour, utc minute, offset, local hour, local minute, taken
  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= {taken3_r,
                fresh_r ? lm_full[5:0] : 6'd0,
                fresh_r ? lh : 5'd0,
                off3_r,
                fresh_r ? um_r : 6'd0,
                fresh_r ? uh_r : 5'd0,
                fresh_r};
    end
  end

  assign res_valid = out_v_r;
  assign res_data  = out_r;

endmodule

/* hw/rtl/nmea_time_sentence_parser.sv */
// NMEA time sentence parser: one result per input request (byte or millisecond tick).
// Top level with input register, configuration registers and stall control.
// Depends on ntsp_pkg, ntsp_line_scan and ntsp_local_time.
//
// Each accepted request (a UART byte or a 1 ms tick) yields exactly one result; a new
// request is taken every cycle while the result side keeps up.
// The pipeline is an input register, the per-byte sentence scanner that holds all
// line and latched-time state, a day-wrap stage and the result register; all four
// stall together when a result is waiting and out_tready is low. Lines end at CR or
// LF and are judged at that byte; line_taken marks the byte that latched a time.
// Configuration writes (index 0 fresh window ms, index 1 ZDA suppress window ms)
// take effect at once and belong in idle periods.
module nmea_time_sentence_parser (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] func: 0 byte, 1 tick
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] time_fresh, [5:1] utc_hour, [11:6] utc_minute, [26:12] zone_offset_min,
  // [31:27] local_hour, [37:32] local_minute, [38] line_taken, [39] zero
  output logic [39:0] out_tdata,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic                   en;
  logic                   in_v_r;
  logic                   func_r;
  logic [7:0]             byte_r;
  logic [31:0]            fresh_ms_r;
  logic [31:0]            suppress_ms_r;
  ntsp_pkg::ntsp_status_t status;
  logic [38:0]            res_data;

  // whole pipeline advances when the result register is free or drained
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_ms_r    <= ntsp_pkg::FRESH_RESET;
      suppress_ms_r <= ntsp_pkg::SUPPRESS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ntsp_pkg::REG_FRESH:    fresh_ms_r    <= cfg_data;
        ntsp_pkg::REG_SUPPRESS: suppress_ms_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (en) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func_r <= in_tuser;
      byte_r <= in_tdata;
    end
  end

  ntsp_line_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .item_valid  (in_v_r),
    .item_func   (func_r),
    .item_byte   (byte_r),
    .suppress_ms (suppress_ms_r),
    .status      (status)
  );

  ntsp_local_time u_local (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .status    (status),
    .fresh_ms  (fresh_ms_r),
    .res_valid (out_tvalid),
    .res_data  (res_data)
  );

  assign out_tdata = {1'b0, res_data};

endmodule

/* bench/nmea_time_sentence_parser_chk.sv */
// Checker for the NMEA time sentence parser: watches the request and result
// streams, predicts each result and compares it field by field. Uses ntsp_pkg.
`timescale 1ns / 1ps

module nmea_time_sentence_parser_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          err_count,
  output int          pending,
  output int          taken_count,
  output int          result_count
);

  typedef struct packed {
    logic        fresh;
    logic [4:0]  uh;
    logic [5:0]  um;
    logic [14:0] zone;
    logic [4:0]  lh;
    logic [5:0]  lm;
    logic        taken;
  } time_res_t;

  // predictor state
  logic [31:0] fresh_win, supp_win, now_ms, stamp, zda_stamp;
  logic [7:0]  line [0:255];
  int          line_len;
  int          hour_q, min_q, zone_q;
  bit          have_t;
  time_res_t   expected_q[$];

  function automatic bit blank_ch(logic [7:0] c);
    return c == 32 || c == 9 || c == 10 || c == 11 || c == 12 || c == 13;
  endfunction

  function automatic bit digit_ch(logic [7:0] c);
    return c >= 48 && c <= 57;
  endfunction

  function automatic int comma_at(int pos);
    for (int i = pos; i < line_len; i++) if (line[i] == ntsp_pkg::CH_COMMA) return i;
    return -1;
  endfunction

  function automatic int zone_number(int pos, int lim);
    int  q, v;
    bit  neg;
    q = pos; v = 0; neg = 0;
    while (q < line_len && blank_ch(line[q])) q++;
    if (q < line_len && line[q] == ntsp_pkg::CH_MINUS) begin
      neg = 1; q++;
    end else if (q < line_len && line[q] == ntsp_pkg::CH_PLUS) begin
      q++;
    end
    while (q < line_len && digit_ch(line[q])) begin
      v = v * 10 + (line[q] - 48);
      q++;
      if (v > lim) break;
    end
    return neg ? -v : v;
  endfunction

  function automatic void latch_zone();
    int pos, c, h, m;
    pos = 0;
    for (int k = 0; k < 5; k++) begin
      c = comma_at(pos);
      if (c < 0) return;
      pos = c + 1;
    end
    h = zone_number(pos, 13);
    c = comma_at(pos);
    if (c < 0) return;
    m = zone_number(c + 1, 59);
    if (m < -59 || m > 59) m = 0;
    zone_q = h * 60 + m;
  endfunction

  // judge a complete line and latch its time when it qualifies
  function automatic bit judge_line();
    int p, c1, c2, tb, hh, mm, ss;
    bit zda, rg;
    logic [7:0] t;
    p = 0; zda = 0; rg = 0;
    while (p < line_len && blank_ch(line[p])) p++;
    if (p >= line_len || line[p] != ntsp_pkg::CH_DOLLAR) return 0;
    c1 = comma_at(p);
    if (c1 < 0) return 0;
    if (c1 - p == 6) begin
      t = line[p+2];
      zda = line[p+1] == ntsp_pkg::CH_G &&
            (t == ntsp_pkg::CH_P || t == ntsp_pkg::CH_N || t == ntsp_pkg::CH_L ||
             t == ntsp_pkg::CH_Q) &&
            line[p+3] == ntsp_pkg::CH_Z && line[p+4] == ntsp_pkg::CH_D &&
            line[p+5] == ntsp_pkg::CH_A;
    end
    for (int q = p; q + 3 <= c1; q++)
      if ((line[q] == ntsp_pkg::CH_R && line[q+1] == ntsp_pkg::CH_M &&
           line[q+2] == ntsp_pkg::CH_C) ||
          (line[q] == ntsp_pkg::CH_G && line[q+1] == ntsp_pkg::CH_G &&
           line[q+2] == ntsp_pkg::CH_A)) begin
        rg = 1;
        break;
      end
    if (!zda && !rg) return 0;
    if (rg && zda_stamp != 0 && (now_ms - zda_stamp) < supp_win) return 0;
    c2 = comma_at(c1 + 1);
    if (c2 < 0) return 0;
    tb = c1 + 1;
    while (tb < c2 && blank_ch(line[tb])) tb++;
    if (c2 - tb < 6) return 0;
    for (int j = 0; j < 6; j++) if (!digit_ch(line[tb+j])) return 0;
    hh = (line[tb] - 48) * 10 + line[tb+1] - 48;
    mm = (line[tb+2] - 48) * 10 + line[tb+3] - 48;
    ss = (line[tb+4] - 48) * 10 + line[tb+5] - 48;
    if (hh > 23 || mm > 59 || ss > 59) return 0;
    hour_q = hh; min_q = mm; have_t = 1; stamp = now_ms;
    if (zda) begin
      latch_zone();
      zda_stamp = now_ms;
    end
    return 1;
  endfunction

  function automatic time_res_t predict_time(logic is_tick, logic [7:0] c);
    time_res_t r;
    int tot;
    r = '0;
    if (is_tick == ntsp_pkg::FUNC_TICK) begin
      now_ms++;
    end else if (c == ntsp_pkg::CH_CR || c == ntsp_pkg::CH_LF) begin
      if (line_len > 0) r.taken = judge_line();
      line_len = 0;
    end else if (line_len < ntsp_pkg::LINE_MAX - 1) begin
      line[line_len] = c;
      line_len++;
    end
    r.fresh = have_t && (now_ms - stamp) < fresh_win;
    r.zone = 15'(zone_q);
    if (r.fresh) begin
      tot = hour_q * 60 + min_q + zone_q;
      tot = ((tot % 1440) + 1440) % 1440;
      r.uh = 5'(hour_q); r.um = 6'(min_q);
      r.lh = 5'(tot / 60); r.lm = 6'(tot % 60);
    end
    return r;
  endfunction

  assign pending = expected_q.size();

  // predict on requests, compare on results
  always @(posedge clk) begin
    time_res_t got, exp_r;
    if (!rst_n) begin
      fresh_win <= ntsp_pkg::FRESH_RESET; supp_win <= ntsp_pkg::SUPPRESS_RESET;
      now_ms = 0; stamp = 0; zda_stamp = 0; line_len = 0;
      hour_q = 0; min_q = 0; zone_q = 0; have_t = 0;
      expected_q.delete();
      err_count <= 0; taken_count <= 0; result_count <= 0;
    end else begin
      if (cfg_we && cfg_index == ntsp_pkg::REG_FRESH) fresh_win <= cfg_data;
      if (cfg_we && cfg_index == ntsp_pkg::REG_SUPPRESS) supp_win <= cfg_data;
      if (in_tvalid && in_tready) expected_q.push_back(predict_time(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        got = {out_tdata[0], out_tdata[5:1], out_tdata[11:6], out_tdata[26:12],
               out_tdata[31:27], out_tdata[37:32], out_tdata[38]};
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          err_count <= err_count + 1;
          if (err_count < 10) $display("unexpected result %h", out_tdata);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.taken) taken_count <= taken_count + 1;
          if (got !== exp_r || out_tdata[39] !== 1'b0) begin
            err_count <= err_count + 1;
            if (err_count < 10)
              $display("mismatch: exp fresh=%0d utc=%0d:%0d zone=%0d loc=%0d:%0d tk=%0d",
                       exp_r.fresh, exp_r.uh, exp_r.um, $signed(exp_r.zone), exp_r.lh,
                       exp_r.lm, exp_r.taken,
                       " got fresh=%0d utc=%0d:%0d zone=%0d loc=%0d:%0d tk=%0d",
                       got.fresh, got.uh, got.um, $signed(got.zone), got.lh,
                       got.lm, got.taken);
          end
        end
      end
    end
  end
endmodule

/* bench/nmea_time_sentence_parser_tb.sv */
// Testbench top for the NMEA time sentence parser: builds sentence and tick
// requests, bursty sending, stalled receiving and verdict. Uses ntsp_pkg and the checker.
`timescale 1ns / 1ps

module nmea_time_sentence_parser_tb;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0, in_tready, in_tuser = 0;
  logic [7:0]  in_tdata = 0;
  logic        out_tvalid, out_tready = 0;
  logic [39:0] out_tdata;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = 0;
  logic [31:0] cfg_data = 0;
  int          err_count, pending, taken_count, result_count;
  int          sent, idle_cycles;
  bit          stall_on = 1;
  string       zda_hdr[4] = '{"$GPZDA", "$GNZDA", "$GLZDA", "$GQZDA"};

  always #4 clk = ~clk;

  nmea_time_sentence_parser i_dut (.*);

  nmea_time_sentence_parser_chk i_chk (.*);

  // receiver stall pattern: runs of ready and not ready
  always @(posedge clk) begin
    if (!stall_on) out_tready <= 1'b1;
    else if ($urandom_range(0, 7) == 0) out_tready <= ~out_tready;
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("watchdog expired");
      $display("nmea_time_sentence_parser_tb failed");
      $finish;
    end
  end

  // one request, with an optional random gap before it
  task automatic send_req(logic kind, logic [7:0] ch);
    if ($urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= ch;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_req(ntsp_pkg::FUNC_BYTE, s[i]);
  endtask

  task automatic ticks(int n);
    repeat (n) send_req(ntsp_pkg::FUNC_TICK, 8'($urandom));
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic string two(int v);
    return $sformatf("%02d", v);
  endfunction

  // a well formed sentence with random content and occasional damage
  function automatic string rand_sentence();
    string s, hdr, tm, z;
    int k;
    k = $urandom_range(0, 5);
    if (k < 2) hdr = zda_hdr[$urandom_range(0, 3)];
    else if (k == 2) hdr = "$GPRMC";
    else if (k == 3) hdr = "$GNGGA";
    else if (k == 4) hdr = "$XXRMCX";
    else hdr = "$GPGSV";
    tm = {two($urandom_range(0, 25)), two($urandom_range(0, 61)),
          two($urandom_range(0, 61)), ".00"};
    if ($urandom_range(0, 7) == 0) tm = {" ", tm};
    if ($urandom_range(0, 9) == 0) tm[$urandom_range(0, 4)] = "x";
    z = $sformatf(",%0d,%0d,2024,%s%0d,%s%0d", $urandom_range(1, 31),
                  $urandom_range(1, 12), $urandom_range(0, 1) ? "-" : "+",
                  $urandom_range(0, 15), $urandom_range(0, 1) ? "-" : " ",
                  $urandom_range(0, 99));
    s = {hdr, ",", tm};
    if (k < 2) begin
      if ($urandom_range(0, 5) != 0) s = {s, z};
    end else s = {s, ",A,4807.038,N"};
    if ($urandom_range(0, 3) == 0) s = {"  ", s};
    return {s, $urandom_range(0, 1) ? "\r\n" : "\n"};
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: each header kind, zone extremes, suppression, bad fields
    send_text("\n$GPZDA,235959.00,01,01,2024,-13,-59\r\n");
    send_text("$GNZDA,000000,1,1,2024,+14,99\n");
    send_text("$GPRMC,120000,A\n");
    ticks(3);
    send_text("\t\v\f $GQZDA,123456,1,1,2024,05\n");
    send_text("$GLZDA,240000,1,1,2024,1,1\n$GPZDA,126000,x\n$GPZDA,12345\n");
    send_text("$GPGGA,  010203,x\n$XYZ,101010,\n$GPZDAX,101010,1\n");
    send_req(ntsp_pkg::FUNC_BYTE, 8'h00); send_req(ntsp_pkg::FUNC_BYTE, 8'hFF);
    send_text("\r\n");
    // long line: prefix parsed, tail dropped
    send_text("$GPZDA,111111,1,1,2024,3,30");
    for (int i = 0; i < 260; i++) send_req(ntsp_pkg::FUNC_BYTE, 8'h41 + 8'(i % 20));
    send_text("\n");

    cfg_write(ntsp_pkg::REG_SUPPRESS, 32'd0);
    send_text("$GPRMC,101010,A\n");
    cfg_write(ntsp_pkg::REG_SUPPRESS, 32'hFFFF_FFFF);
    cfg_write(ntsp_pkg::REG_FRESH, 32'd0);
    send_text("$GPZDA,101010,1,1,2024,1,0\n");
    cfg_write(ntsp_pkg::REG_FRESH, 32'd5);
    send_text("$GPZDA,020202,1,1,2024,2,0\n");
    ticks(8);
    cfg_write(ntsp_pkg::REG_FRESH, 32'hFFFF_FFFF);
    cfg_write(ntsp_pkg::REG_SUPPRESS, 32'd20);

    // random phases over several settings
    while (sent < 1450) begin
      if ($urandom_range(0, 9) == 0) stall_on = $urandom_range(0, 1);
      case ($urandom_range(0, 9))
        0: begin
          cfg_write(ntsp_pkg::REG_FRESH,
                    $urandom_range(0, 1) ? 32'($urandom_range(1, 60)) : $urandom);
          cfg_write(ntsp_pkg::REG_SUPPRESS, 32'($urandom_range(0, 40)));
        end
        1, 2: ticks($urandom_range(1, 25));
        3: begin
          repeat ($urandom_range(1, 10)) send_req(ntsp_pkg::FUNC_BYTE, 8'($urandom));
        end
        default: send_text(rand_sentence());
      endcase
    end

    in_tvalid <= 1'b0;
    stall_on = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("sent %0d requests, checked %0d results, %0d lines latched a time",
             sent, result_count, taken_count);
    if (err_count == 0) $display("nmea_time_sentence_parser_tb passed");
    else $display("nmea_time_sentence_parser_tb failed");
    $finish;
  end
endmodule
